// File: rtl/ialu_pkg.sv
`default_nettype none

package ialu_pkg;

   localparam int DATA_W = 32;
   localparam int HALF_W = 16;
   localparam int CNT_W  = 5;

   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 6;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [3:0] {
      KIND_ADD  = 4'd0,
      KIND_SUB  = 4'd1,
      KIND_ADDX = 4'd2,
      KIND_SUBX = 4'd3,
      KIND_CMP  = 4'd4,
      KIND_AND  = 4'd5,
      KIND_OR   = 4'd6,
      KIND_EOR  = 4'd7,
      KIND_ADDA = 4'd8,
      KIND_SUBA = 4'd9,
      KIND_CMPA = 4'd10,
      KIND_MULU = 4'd11,
      KIND_MULS = 4'd12,
      KIND_DIVU = 4'd13,
      KIND_DIVS = 4'd14
   } kind_type;

   typedef enum logic [1:0] {
      SIZE_BYTE = 2'd0,
      SIZE_WORD = 2'd1,
      SIZE_LONG = 2'd2
   } size_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_RUN,
      ST_POST,
      ST_DONE
   } state_type;

   // bit order matches the condition code byte: X N Z V C
   typedef struct packed {
      logic x;
      logic n;
      logic z;
      logic v;
      logic c;
   } flags_type;

endpackage

`default_nettype wire

// File: rtl/integer_alu_with_condition_codes_core.sv
// Integer ALU with X/N/Z/V/C condition codes, bit-serial datapath.
// Input channel req_*: one transaction carries an operation (req_tuser) and
// the source and destination operands (req_tdata). Result channel rsp_*:
// one transaction per input carries the value, the write flag, the new
// flags and the divide-by-zero mark.
// Add, subtract, compare and logic operations run one bit per cycle
// through a serial adder over 8, 16 or 32 bits for byte, word or long
// (all 32 bits for the address forms), between an accept step and a
// post step; the next input is taken only once the result is posted.
// Multiplies are shift-add over 16 bits, one multiplier bit per cycle.
// Divides are restoring, one quotient bit per cycle through a 17-bit
// subtractor; signed ones take magnitudes first, and all fix signs after.
// A zero divisor or an unused operation code skips straight to posting.
// The flags are updated when the result is posted to the output register.
// A new transaction is accepted while the previous result still waits in
// the output register; if rsp_tready stays low the finished result holds
// in the datapath until the output register frees, and req_tready stays
// low meanwhile. Reset clears the flags, drops any pending result and
// returns the block to idle.
`default_nettype none

module integer_alu_with_condition_codes_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // src_operand[31:0], dst_operand[63:32]
   input  wire logic [ialu_pkg::REQ_DATA_W-1:0]      req_tdata,
   // kind[3:0], size[5:4]
   input  wire logic [ialu_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // result_value[31:0], result_written[32], flag_x[33], flag_n[34],
   // flag_z[35], flag_v[36], flag_c[37], divide_by_zero[38], zero pad[39]
   output logic [ialu_pkg::RSP_DATA_W-1:0]           rsp_tdata
);

   localparam int W = ialu_pkg::DATA_W;
   localparam int H = ialu_pkg::HALF_W;

   ialu_pkg::state_type          state_ff, state_in;
   ialu_pkg::kind_type           kind_ff, kind_in;
   ialu_pkg::size_type           len_ff, len_in;
   ialu_pkg::flags_type          flags_ff, flags_in;
   logic [W-1:0]                 a_ff, a_in;
   logic [W-1:0]                 b_ff, b_in;
   logic [W-1:0]                 r_ff, r_in;
   logic [H:0]                   rem_ff, rem_in;
   logic [ialu_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                         carry_ff, carry_in;
   logic                         nz_ff, nz_in;
   logic                         last_a_ff, last_a_in;
   logic                         last_b_ff, last_b_in;
   logic                         neg_q_ff, neg_q_in;
   logic                         neg_r_ff, neg_r_in;
   logic                         dz_ff, dz_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ialu_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // request decode
   ialu_pkg::kind_type  in_kind;
   ialu_pkg::size_type  in_len;
   logic [W-1:0]        in_src, in_dst, in_mask, in_sext_src, in_sext_dst;
   logic [ialu_pkg::CNT_W-1:0] in_last;

   // serial step
   logic is_sub, is_mul, is_div;
   logic abit, bbit, sum_bit, carry_nx, step_bit;
   logic [W-1:0]   mul_sum;
   logic [H:0]     rem_sh;
   logic [H+1:0]   div_diff;
   logic           q_bit;

   // result assembly
   ialu_pkg::flags_type flags_new;
   logic [W-1:0] res_aligned, res_out;
   logic         wr_out, v_arith, c_arith, div_ovf, load_w;

   assign in_kind     = ialu_pkg::kind_type'(req_tuser[3:0]);
   assign in_src      = req_tdata[W-1:0];
   assign in_dst      = req_tdata[2*W-1:W];
   assign in_sext_src = {{(W-H){in_src[H-1]}}, in_src[H-1:0]};
   assign in_sext_dst = {{(W-H){in_dst[H-1]}}, in_dst[H-1:0]};

   always_comb begin
      case (ialu_pkg::size_type'(req_tuser[5:4]))
         ialu_pkg::SIZE_BYTE: begin
            in_len  = ialu_pkg::SIZE_BYTE;
            in_mask = {{(W-8){1'b0}}, 8'hFF};
            in_last = ialu_pkg::CNT_W'(7);
         end
         ialu_pkg::SIZE_WORD: begin
            in_len  = ialu_pkg::SIZE_WORD;
            in_mask = {{(W-H){1'b0}}, {H{1'b1}}};
            in_last = ialu_pkg::CNT_W'(H - 1);
         end
         default: begin
            in_len  = ialu_pkg::SIZE_LONG;
            in_mask = {W{1'b1}};
            in_last = ialu_pkg::CNT_W'(W - 1);
         end
      endcase
   end

   assign is_sub = (kind_ff == ialu_pkg::KIND_SUB)  || (kind_ff == ialu_pkg::KIND_SUBX) ||
                   (kind_ff == ialu_pkg::KIND_CMP)  || (kind_ff == ialu_pkg::KIND_SUBA) ||
                   (kind_ff == ialu_pkg::KIND_CMPA);
   assign is_mul = (kind_ff == ialu_pkg::KIND_MULU) || (kind_ff == ialu_pkg::KIND_MULS);
   assign is_div = (kind_ff == ialu_pkg::KIND_DIVU) || (kind_ff == ialu_pkg::KIND_DIVS);

   assign abit     = a_ff[0];
   assign bbit     = b_ff[0];
   assign sum_bit  = abit ^ bbit ^ carry_ff;
   assign carry_nx = (abit & bbit) | (carry_ff & (abit ^ bbit));

   always_comb begin
      case (kind_ff)
         ialu_pkg::KIND_AND: step_bit = abit & bbit;
         ialu_pkg::KIND_OR:  step_bit = abit | bbit;
         ialu_pkg::KIND_EOR: step_bit = abit ^ bbit;
         default:            step_bit = sum_bit;
      endcase
   end

   // two's complement multiplier: the sign bit weighs negative
   assign mul_sum = ((kind_ff == ialu_pkg::KIND_MULS) && (cnt_ff == '0)) ?
                    (r_ff - a_ff) : (r_ff + a_ff);

   assign rem_sh   = {rem_ff[H-1:0], r_ff[W-1]};
   assign div_diff = {1'b0, rem_sh} - {2'b00, b_ff[H-1:0]};
   assign q_bit    = ~div_diff[H+1];

   // result assembly for the posting cycle
   always_comb begin
      case (len_ff)
         ialu_pkg::SIZE_BYTE: res_aligned = {{(W-8){1'b0}}, r_ff[W-1:W-8]};
         ialu_pkg::SIZE_WORD: res_aligned = {{(W-H){1'b0}}, r_ff[W-1:W-H]};
         default:             res_aligned = r_ff;
      endcase
   end

   assign v_arith = ~(last_a_ff ^ last_b_ff) & (last_a_ff ^ r_ff[W-1]);
   assign c_arith = is_sub ? ~carry_ff : carry_ff;
   assign div_ovf = (kind_ff == ialu_pkg::KIND_DIVS) ?
                    ~((&r_ff[W-1:H-1]) | ~(|r_ff[W-1:H-1])) :
                    (|r_ff[W-1:H]);

   always_comb begin
      flags_new = flags_ff;
      res_out   = '0;
      wr_out    = 1'b0;
      case (kind_ff)
         ialu_pkg::KIND_ADD, ialu_pkg::KIND_SUB, ialu_pkg::KIND_ADDX,
         ialu_pkg::KIND_SUBX, ialu_pkg::KIND_CMP: begin
            res_out     = res_aligned;
            flags_new.n = r_ff[W-1];
            // extended ops only ever clear Z
            flags_new.z = ((kind_ff == ialu_pkg::KIND_ADDX) ||
                           (kind_ff == ialu_pkg::KIND_SUBX)) ? (~nz_ff & flags_ff.z) : ~nz_ff;
            flags_new.v = v_arith;
            flags_new.c = c_arith;
            if (kind_ff != ialu_pkg::KIND_CMP) begin
               flags_new.x = c_arith;
               wr_out      = 1'b1;
            end
         end
         ialu_pkg::KIND_AND, ialu_pkg::KIND_OR, ialu_pkg::KIND_EOR: begin
            res_out     = res_aligned;
            flags_new.n = r_ff[W-1];
            flags_new.z = ~nz_ff;
            flags_new.v = 1'b0;
            flags_new.c = 1'b0;
            wr_out      = 1'b1;
         end
         ialu_pkg::KIND_ADDA, ialu_pkg::KIND_SUBA: begin
            res_out = r_ff;
            wr_out  = 1'b1;
         end
         ialu_pkg::KIND_CMPA: begin
            res_out     = r_ff;
            flags_new.n = r_ff[W-1];
            flags_new.z = ~nz_ff;
            flags_new.v = v_arith;
            flags_new.c = c_arith;
         end
         ialu_pkg::KIND_MULU, ialu_pkg::KIND_MULS: begin
            res_out     = r_ff;
            flags_new.n = r_ff[W-1];
            flags_new.z = (r_ff == '0);
            flags_new.v = 1'b0;
            flags_new.c = 1'b0;
            wr_out      = 1'b1;
         end
         ialu_pkg::KIND_DIVU, ialu_pkg::KIND_DIVS: begin
            if (dz_ff) begin
               res_out = '0;
            end else if (div_ovf) begin
               flags_new.v = 1'b1;
            end else begin
               res_out     = {rem_ff[H-1:0], r_ff[H-1:0]};
               flags_new.n = r_ff[H-1];
               flags_new.z = (r_ff[H-1:0] == '0);
               flags_new.v = 1'b0;
               flags_new.c = 1'b0;
               wr_out      = 1'b1;
            end
         end
         default: begin
            res_out = '0;
         end
      endcase
   end

   assign load_w = (state_ff == ialu_pkg::ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      len_in       = len_ff;
      flags_in     = flags_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      r_in         = r_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      carry_in     = carry_ff;
      nz_in        = nz_ff;
      last_a_in    = last_a_ff;
      last_b_in    = last_b_ff;
      neg_q_in     = neg_q_ff;
      neg_r_in     = neg_r_ff;
      dz_in        = dz_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;

      case (state_ff)
         ialu_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               kind_in  = in_kind;
               len_in   = in_len;
               r_in     = '0;
               rem_in   = '0;
               nz_in    = 1'b0;
               dz_in    = 1'b0;
               neg_q_in = 1'b0;
               neg_r_in = 1'b0;
               cnt_in   = in_last;
               state_in = ialu_pkg::ST_RUN;
               case (in_kind)
                  ialu_pkg::KIND_ADD, ialu_pkg::KIND_ADDX: begin
                     a_in     = in_dst & in_mask;
                     b_in     = in_src & in_mask;
                     carry_in = (in_kind == ialu_pkg::KIND_ADDX) & flags_ff.x;
                  end
                  ialu_pkg::KIND_SUB, ialu_pkg::KIND_SUBX, ialu_pkg::KIND_CMP: begin
                     a_in     = in_dst & in_mask;
                     b_in     = ~(in_src & in_mask);
                     carry_in = ~((in_kind == ialu_pkg::KIND_SUBX) & flags_ff.x);
                  end
                  ialu_pkg::KIND_AND, ialu_pkg::KIND_OR, ialu_pkg::KIND_EOR: begin
                     a_in     = in_dst & in_mask;
                     b_in     = in_src & in_mask;
                     carry_in = 1'b0;
                  end
                  ialu_pkg::KIND_ADDA: begin
                     len_in   = ialu_pkg::SIZE_LONG;
                     cnt_in   = ialu_pkg::CNT_W'(W - 1);
                     a_in     = in_dst;
                     b_in     = in_sext_src;
                     carry_in = 1'b0;
                  end
                  ialu_pkg::KIND_SUBA, ialu_pkg::KIND_CMPA: begin
                     len_in   = ialu_pkg::SIZE_LONG;
                     cnt_in   = ialu_pkg::CNT_W'(W - 1);
                     a_in     = in_dst;
                     b_in     = ~in_sext_src;
                     carry_in = 1'b1;
                  end
                  ialu_pkg::KIND_MULU, ialu_pkg::KIND_MULS: begin
                     len_in = ialu_pkg::SIZE_LONG;
                     cnt_in = ialu_pkg::CNT_W'(H - 1);
                     a_in   = (in_kind == ialu_pkg::KIND_MULS) ? in_sext_dst :
                              {{(W-H){1'b0}}, in_dst[H-1:0]};
                     b_in   = {{(W-H){1'b0}}, in_src[H-1:0]};
                  end
                  ialu_pkg::KIND_DIVU, ialu_pkg::KIND_DIVS: begin
                     len_in = ialu_pkg::SIZE_LONG;
                     cnt_in = ialu_pkg::CNT_W'(W - 1);
                     r_in   = in_dst;
                     b_in   = {{(W-H){1'b0}}, in_src[H-1:0]};
                     if (in_src[H-1:0] == '0) begin
                        dz_in    = 1'b1;
                        state_in = ialu_pkg::ST_DONE;
                     end else if (in_kind == ialu_pkg::KIND_DIVS) begin
                        neg_q_in = in_dst[W-1] ^ in_src[H-1];
                        neg_r_in = in_dst[W-1];
                        state_in = ialu_pkg::ST_PREP;
                     end
                  end
                  default: begin
                     state_in = ialu_pkg::ST_DONE;
                  end
               endcase
            end
         end
         ialu_pkg::ST_PREP: begin
            // take magnitudes for the signed divide
            r_in          = r_ff[W-1] ? (~r_ff + W'(1)) : r_ff;
            b_in[H-1:0]   = b_ff[H-1] ? (~b_ff[H-1:0] + H'(1)) : b_ff[H-1:0];
            state_in      = ialu_pkg::ST_RUN;
         end
         ialu_pkg::ST_RUN: begin
            cnt_in = cnt_ff - ialu_pkg::CNT_W'(1);
            if (is_mul) begin
               if (bbit) begin
                  r_in = mul_sum;
               end
               a_in = {a_ff[W-2:0], 1'b0};
               b_in = {1'b0, b_ff[W-1:1]};
            end else if (is_div) begin
               rem_in = q_bit ? div_diff[H:0] : rem_sh;
               r_in   = {r_ff[W-2:0], q_bit};
            end else begin
               r_in      = {step_bit, r_ff[W-1:1]};
               a_in      = {1'b0, a_ff[W-1:1]};
               b_in      = {1'b0, b_ff[W-1:1]};
               carry_in  = carry_nx;
               nz_in     = nz_ff | step_bit;
               last_a_in = abit;
               last_b_in = bbit;
            end
            if (cnt_ff == '0) begin
               state_in = is_div ? ialu_pkg::ST_POST : ialu_pkg::ST_DONE;
            end
         end
         ialu_pkg::ST_POST: begin
            // restore signs of quotient and remainder
            r_in = neg_q_ff ? (~r_ff + W'(1)) : r_ff;
            rem_in[H-1:0] = neg_r_ff ? (~rem_ff[H-1:0] + H'(1)) : rem_ff[H-1:0];
            state_in = ialu_pkg::ST_DONE;
         end
         ialu_pkg::ST_DONE: begin
            if (load_w) begin
               flags_in     = flags_new;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, dz_ff, flags_new.c, flags_new.v, flags_new.z,
                               flags_new.n, flags_new.x, wr_out, res_out};
               state_in     = ialu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ialu_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ialu_pkg::ST_IDLE;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      len_ff      <= len_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      r_ff        <= r_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      carry_ff    <= carry_in;
      nz_ff       <= nz_in;
      last_a_ff   <= last_a_in;
      last_b_ff   <= last_b_in;
      neg_q_ff    <= neg_q_in;
      neg_r_ff    <= neg_r_in;
      dz_ff       <= dz_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted twice without finishing a transaction");

   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      !load_w |=> $stable(flags_ff))
      else $error("flags changed without posting a result");

   a_zero_divide_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[38]) |-> (!rsp_tdata[32] && (rsp_tdata[31:0] == '0)))
      else $error("zero divide reported with a written result");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ialu_pkg::ST_RUN && cnt_ff == '0) |=> (state_ff != ialu_pkg::ST_RUN))
      else $error("serial run did not end at terminal count");

endmodule

`default_nettype wire

// File: dv/integer_alu_with_condition_codes_core_test.sv
`timescale 1ns / 1ps

module integer_alu_with_condition_codes_core_test;

   // operation code left unused by the block, and the size code read as long
   localparam logic [3:0] KIND_UNUSED = 4'd15;
   localparam logic [1:0] SIZE_ODD    = 2'd3;
   localparam int DIR_ROWS  = 25;
   localparam int PHASE_OPS = 150;

   typedef struct packed {
      logic                dz;
      ialu_pkg::flags_type flags;
      logic                written;
      logic [31:0]         value;
   } alu_rsp_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [1:0]  size;
      logic [31:0] src;
      logic [31:0] dst;
      logic        typed;
      alu_rsp_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ialu_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [ialu_pkg::REQ_USER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b1;
   logic [ialu_pkg::RSP_DATA_W-1:0] rsp_tdata;

   ialu_pkg::flags_type ccr_model = '0;
   alu_rsp_type awaited_rsp[$];
   int idle_pct  = 0;
   int stall_pct = 0;
   int err_count = 0;
   int n_sent    = 0;
   int n_checked = 0;

   // flags written as X N Z V C
   stim_row_type dir_tab [DIR_ROWS] = '{
      '{ialu_pkg::KIND_ADD,  ialu_pkg::SIZE_BYTE, 32'h0000_0000, 32'h0000_0000, 1'b1,
        '{1'b0, 5'b00100, 1'b1, 32'h0000_0000}},
      '{ialu_pkg::KIND_ADD,  ialu_pkg::SIZE_BYTE, 32'h0000_00FF, 32'h0000_0001, 1'b1,
        '{1'b0, 5'b10101, 1'b1, 32'h0000_0000}},
      '{ialu_pkg::KIND_ADDX, ialu_pkg::SIZE_BYTE, 32'h0000_0000, 32'h0000_0000, 1'b1,
        '{1'b0, 5'b00000, 1'b1, 32'h0000_0001}},
      '{ialu_pkg::KIND_DIVU, ialu_pkg::SIZE_WORD, 32'h0000_0000, 32'h0000_007B, 1'b1,
        '{1'b1, 5'b00000, 1'b0, 32'h0000_0000}},
      '{KIND_UNUSED,         SIZE_ODD,            32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
        '{1'b0, 5'b00000, 1'b0, 32'h0000_0000}},
      '{ialu_pkg::KIND_SUB,  ialu_pkg::SIZE_LONG, 32'h0000_0001, 32'h0000_0000, 1'b1,
        '{1'b0, 5'b11001, 1'b1, 32'hFFFF_FFFF}},
      '{ialu_pkg::KIND_DIVU, ialu_pkg::SIZE_WORD, 32'h0000_0001, 32'h0001_0000, 1'b1,
        '{1'b0, 5'b11011, 1'b0, 32'h0000_0000}},
      '{ialu_pkg::KIND_ADD,  ialu_pkg::SIZE_LONG, 32'h0000_0001, 32'h7FFF_FFFF, 1'b0, '0},
      '{ialu_pkg::KIND_ADD,  ialu_pkg::SIZE_WORD, 32'h0000_FFFF, 32'h0000_FFFF, 1'b0, '0},
      '{ialu_pkg::KIND_SUB,  ialu_pkg::SIZE_BYTE, 32'h0000_0001, 32'h0000_0080, 1'b0, '0},
      '{ialu_pkg::KIND_SUBX, ialu_pkg::SIZE_WORD, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{ialu_pkg::KIND_ADDX, ialu_pkg::SIZE_LONG, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
      '{ialu_pkg::KIND_CMP,  ialu_pkg::SIZE_BYTE, 32'h0000_007F, 32'h0000_0080, 1'b0, '0},
      '{ialu_pkg::KIND_AND,  ialu_pkg::SIZE_LONG, 32'hFFFF_0000, 32'h0F0F_0F0F, 1'b0, '0},
      '{ialu_pkg::KIND_OR,   ialu_pkg::SIZE_WORD, 32'h1234_8000, 32'h0000_0001, 1'b0, '0},
      '{ialu_pkg::KIND_EOR,  ialu_pkg::SIZE_BYTE, 32'h0000_00FF, 32'h0000_0080, 1'b0, '0},
      '{ialu_pkg::KIND_ADDA, ialu_pkg::SIZE_WORD, 32'h0000_8000, 32'h0000_0000, 1'b0, '0},
      '{ialu_pkg::KIND_SUBA, ialu_pkg::SIZE_WORD, 32'h0000_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
      '{ialu_pkg::KIND_CMPA, ialu_pkg::SIZE_WORD, 32'h0000_7FFF, 32'h8000_0000, 1'b0, '0},
      '{ialu_pkg::KIND_MULU, ialu_pkg::SIZE_WORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
      '{ialu_pkg::KIND_MULS, ialu_pkg::SIZE_WORD, 32'h0000_8000, 32'h0000_8000, 1'b0, '0},
      '{ialu_pkg::KIND_DIVS, ialu_pkg::SIZE_WORD, 32'h1234_0000, 32'h0000_0005, 1'b0, '0},
      '{ialu_pkg::KIND_DIVS, ialu_pkg::SIZE_WORD, 32'h0000_FFFF, 32'h8000_0000, 1'b0, '0},
      '{ialu_pkg::KIND_DIVS, ialu_pkg::SIZE_WORD, 32'h0000_0007, 32'hFFFF_FF9C, 1'b0, '0},
      '{ialu_pkg::KIND_ADD,  SIZE_ODD,            32'h8000_0000, 32'h8000_0000, 1'b0, '0}
   };

   integer_alu_with_condition_codes_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // compute the response and advance the flag model
   function automatic alu_rsp_type predict_alu(input logic [3:0] kind, input logic [1:0] sz,
                                               input logic [31:0] src, input logic [31:0] dst);
      int unsigned nbits;
      logic [63:0] mask, top, d, s, cin, full, res;
      logic [31:0] sv, r32;
      logic cy;
      longint sdst, sdiv, quo, rem;
      logic ovf;
      ialu_pkg::flags_type f;
      alu_rsp_type o;
      f = ccr_model;
      o = '0;
      nbits = (sz == ialu_pkg::SIZE_BYTE) ? 8 : ((sz == ialu_pkg::SIZE_WORD) ? 16 : 32);
      mask = (64'd1 << nbits) - 64'd1;
      top = 64'd1 << (nbits - 1);
      d = {32'd0, dst} & mask;
      s = {32'd0, src} & mask;
      cin = {63'd0, ccr_model.x};
      sv = {{16{src[15]}}, src[15:0]};
      case (kind)
         ialu_pkg::KIND_ADD, ialu_pkg::KIND_ADDX: begin
            full = d + s + ((kind == ialu_pkg::KIND_ADDX) ? cin : 64'd0);
            cy = full[nbits];
            res = full & mask;
            f.n = |(res & top);
            // extended add only ever clears Z
            f.z = (res == 64'd0) && (kind == ialu_pkg::KIND_ADD || ccr_model.z);
            f.v = |((d ^ res) & (s ^ res) & top);
            f.c = cy;
            f.x = cy;
            o.written = 1'b1;
            o.value = res[31:0];
         end
         ialu_pkg::KIND_SUB, ialu_pkg::KIND_SUBX, ialu_pkg::KIND_CMP: begin
            if (kind == ialu_pkg::KIND_SUBX) cin = {63'd0, ccr_model.x};
            else cin = 64'd0;
            cy = (s + cin) > d;
            res = (d - s - cin) & mask;
            f.n = |(res & top);
            f.z = (res == 64'd0) && (kind != ialu_pkg::KIND_SUBX || ccr_model.z);
            f.v = |((d ^ s) & (d ^ res) & top);
            f.c = cy;
            if (kind != ialu_pkg::KIND_CMP) begin
               f.x = cy;
               o.written = 1'b1;
            end
            o.value = res[31:0];
         end
         ialu_pkg::KIND_AND, ialu_pkg::KIND_OR, ialu_pkg::KIND_EOR: begin
            if (kind == ialu_pkg::KIND_AND) res = d & s;
            else if (kind == ialu_pkg::KIND_OR) res = d | s;
            else res = d ^ s;
            f.n = |(res & top);
            f.z = (res == 64'd0);
            f.v = 1'b0;
            f.c = 1'b0;
            o.written = 1'b1;
            o.value = res[31:0];
         end
         ialu_pkg::KIND_ADDA: begin
            o.value = dst + sv;
            o.written = 1'b1;
         end
         ialu_pkg::KIND_SUBA: begin
            o.value = dst - sv;
            o.written = 1'b1;
         end
         ialu_pkg::KIND_CMPA: begin
            r32 = dst - sv;
            f.n = r32[31];
            f.z = (r32 == 32'd0);
            f.v = (dst[31] ^ sv[31]) & (dst[31] ^ r32[31]);
            f.c = sv > dst;
            o.value = r32;
         end
         ialu_pkg::KIND_MULU, ialu_pkg::KIND_MULS: begin
            if (kind == ialu_pkg::KIND_MULU)
               quo = longint'(src[15:0]) * longint'(dst[15:0]);
            else
               quo = longint'($signed(src[15:0])) * longint'($signed(dst[15:0]));
            r32 = quo[31:0];
            f.n = r32[31];
            f.z = (r32 == 32'd0);
            f.v = 1'b0;
            f.c = 1'b0;
            o.written = 1'b1;
            o.value = r32;
         end
         ialu_pkg::KIND_DIVU, ialu_pkg::KIND_DIVS: begin
            if (src[15:0] == 16'd0) begin
               o.dz = 1'b1;
            end else begin
               if (kind == ialu_pkg::KIND_DIVU) begin
                  sdst = longint'(dst);
                  sdiv = longint'(src[15:0]);
               end else begin
                  sdst = longint'($signed(dst));
                  sdiv = longint'($signed(src[15:0]));
               end
               quo = sdst / sdiv;
               rem = sdst % sdiv;
               if (kind == ialu_pkg::KIND_DIVU) ovf = quo > 65535;
               else ovf = (quo > 32767) || (quo < -32768);
               if (ovf) begin
                  f.v = 1'b1;
               end else begin
                  o.value = {rem[15:0], quo[15:0]};
                  f.n = quo[15];
                  f.z = (quo[15:0] == 16'd0);
                  f.v = 1'b0;
                  f.c = 1'b0;
                  o.written = 1'b1;
               end
            end
         end
         default: ;
      endcase
      ccr_model = f;
      o.flags = f;
      return o;
   endfunction

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         3: return $urandom_range(255);
         4: begin
            case ($urandom_range(3))
               0: return {16'($urandom_range(16'hFFFF)), 16'h0080};
               1: return {16'($urandom_range(16'hFFFF)), 16'h007F};
               2: return {16'($urandom_range(16'hFFFF)), 16'h8000};
               default: return {16'($urandom_range(16'hFFFF)), 16'h7FFF};
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         err_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // hold the transaction until accepted; valid stays high for a following one
   task automatic push_item(input logic [3:0] kind, input logic [1:0] sz,
                            input logic [31:0] src, input logic [31:0] dst,
                            input logic typed, input alu_rsp_type want);
      alu_rsp_type pred;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {dst, src};
      req_tuser <= {sz, kind};
      do @(posedge clock); while (!req_tready);
      pred = predict_alu(kind, sz, src, dst);
      awaited_rsp.push_back(typed ? want : pred);
      n_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      alu_rsp_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.value   = rsp_tdata[31:0];
         got.written = rsp_tdata[32];
         got.flags.x = rsp_tdata[33];
         got.flags.n = rsp_tdata[34];
         got.flags.z = rsp_tdata[35];
         got.flags.v = rsp_tdata[36];
         got.flags.c = rsp_tdata[37];
         got.dz      = rsp_tdata[38];
         if (awaited_rsp.size() == 0) begin
            err_count++;
            $display("%0t: unexpected result transaction, actual %h", $time, rsp_tdata);
         end else begin
            want = awaited_rsp.pop_front();
            n_checked++;
            check_field("result_value", want.value, got.value);
            check_field("result_written", 32'(want.written), 32'(got.written));
            check_field("flag_x", 32'(want.flags.x), 32'(got.flags.x));
            check_field("flag_n", 32'(want.flags.n), 32'(got.flags.n));
            check_field("flag_z", 32'(want.flags.z), 32'(got.flags.z));
            check_field("flag_v", 32'(want.flags.v), 32'(got.flags.v));
            check_field("flag_c", 32'(want.flags.c), 32'(got.flags.c));
            check_field("divide_by_zero", 32'(want.dz), 32'(got.dz));
         end
      end
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #(64'd10_000_000);
      $display("integer_alu_with_condition_codes_core_test: errors");
      $finish;
   end

   initial begin
      int ph, i, q;
      logic [3:0] k;
      logic [1:0] sz;
      logic [31:0] s, d;
      longint p, r, mag;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < DIR_ROWS; i++)
         push_item(dir_tab[i].kind, dir_tab[i].size, dir_tab[i].src, dir_tab[i].dst,
                   dir_tab[i].typed, dir_tab[i].want);
      drain_results();

      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 77; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 77; end
            default: begin idle_pct = 26; stall_pct = 26; end
         endcase
         for (i = 0; i < PHASE_OPS; i++) begin
            if ($urandom_range(31) == 0) k = KIND_UNUSED;
            else k = 4'($urandom_range(14));
            sz = ($urandom_range(15) == 0) ? SIZE_ODD : 2'($urandom_range(2));
            s = rand_operand();
            d = rand_operand();
            if (k == ialu_pkg::KIND_DIVU || k == ialu_pkg::KIND_DIVS) begin
               case ($urandom_range(7))
                  0: s[15:0] = 16'd0;
                  1, 2: ;
                  default: begin
                     // build a dividend whose quotient fits in most cases
                     if (s[15:0] == 16'd0) s[15:0] = 16'($urandom_range(1, 16'hFFFF));
                     if (k == ialu_pkg::KIND_DIVU) begin
                        p = longint'($urandom_range(16'hFFFF)) * longint'(s[15:0]);
                        d = 32'(p + $urandom_range(s[15:0] - 1));
                     end else begin
                        q = $urandom_range(16'hFFFF) - 32768;
                        mag = longint'($signed(s[15:0]));
                        p = longint'(q) * mag;
                        if (mag < 0) mag = -mag;
                        r = longint'($urandom_range(32'(mag - 1)));
                        if (p < 0) r = -r;
                        d = 32'(p + r);
                     end
                  end
               endcase
            end
            push_item(k, sz, s, d, 1'b0, '0);
         end
         // let the block go idle before the next pacing phase
         drain_results();
      end

      repeat (60) @(posedge clock);
      $display("covered %0d directed and %0d random operations over four pacing phases",
               DIR_ROWS, n_sent - DIR_ROWS);
      $display("%0d results checked field by field, %0d mismatches", n_checked, err_count);
      if (err_count == 0)
         $display("integer_alu_with_condition_codes_core_test: clean");
      else
         $display("integer_alu_with_condition_codes_core_test: errors");
      $finish;
   end

endmodule

// File: files.f
rtl/ialu_pkg.sv
rtl/integer_alu_with_condition_codes_core.sv
dv/integer_alu_with_condition_codes_core_test.sv
